### hw/rtl/pce_pkg.sv
package pce_pkg;

    // Configuration port and register indexes.
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TSTEP  = 3'd4;

    // Request kinds.
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_ADVANCE = 2'd1;
    localparam logic [1:0] REQ_WALL    = 2'd2;
    localparam logic [1:0] REQ_PAIR    = 2'd3;

    // Field widths.
    localparam int IDX_W  = 6;
    localparam int EXT_W  = 31;
    localparam int MASS_W = 16;
    localparam int MSUM_W = 17;
    localparam int NUM_W  = 50;
    localparam int MAG_W  = 49;

    // One particle entry as kept in the table.
    typedef struct packed {
        logic               is_square;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [EXT_W-1:0]   extent;
        logic [MASS_W-1:0]  mass;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_CAP_B,
        ST_ADV_X,
        ST_ADV_Y,
        ST_ADV_PY,
        ST_WALL,
        ST_OVL0,
        ST_OVL1,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_R,
        ST_SQ_CMP,
        ST_NUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RESP,
        ST_WB_A,
        ST_WB_B,
        ST_EMIT_A,
        ST_EMIT_B
    } state_t;

    // Saturate a wide signed value to 32 signed bits.
    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [64:0] hi;
        logic signed [64:0] lo;
        hi = 65'sd2147483647;
        lo = -65'sd2147483648;
        if (v > hi) sat32 = 32'sh7fffffff;
        else if (v < lo) sat32 = 32'sh80000000;
        else sat32 = v[31:0];
    endfunction

    // Negate with the most negative value mapping to the most positive.
    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        if (v == 32'sh80000000) neg_sat = 32'sh7fffffff;
        else neg_sat = -v;
    endfunction

    // Apply the sign to a quotient magnitude and saturate to 32 bits.
    function automatic logic signed [31:0] quot_to_vel(input logic [MAG_W-1:0] q,
                                                       input logic neg);
        logic [MAG_W-1:0] nq;
        nq = -q;
        if (!neg) begin
            if (q > MAG_W'(32'h7fffffff)) quot_to_vel = 32'sh7fffffff;
            else quot_to_vel = q[31:0];
        end
        else begin
            if (q > MAG_W'(33'h080000000)) quot_to_vel = 32'sh80000000;
            else quot_to_vel = nq[31:0];
        end
    endfunction

endpackage

### hw/rtl/pce_if.sv
// Request channel: one item per request.
interface pce_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic [5:0]                 index_a;
    logic [5:0]                 index_b;
    logic                       is_square;
    logic signed [31:0]         pos_x;
    logic signed [31:0]         pos_y;
    logic signed [31:0]         vel_x;
    logic signed [31:0]         vel_y;
    logic [30:0]                extent;
    logic [15:0]                mass;

    modport source (
        output valid, req_type, index_a, index_b, is_square,
               pos_x, pos_y, vel_x, vel_y, extent, mass,
        input  ready
    );
    modport sink (
        input  valid, req_type, index_a, index_b, is_square,
               pos_x, pos_y, vel_x, vel_y, extent, mass,
        output ready
    );
endinterface

// Result channel: one or two items per request.
interface pce_res_if;
    logic               valid;
    logic               ready;
    logic [5:0]         entry;
    logic               hit;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               last;

    modport source (
        output valid, entry, hit, new_pos_x, new_pos_y, new_vel_x, new_vel_y, last,
        input  ready
    );
    modport sink (
        input  valid, entry, hit, new_pos_x, new_pos_y, new_vel_x, new_vel_y, last,
        output ready
    );
endinterface

### hw/rtl/pce_div.sv
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
module pce_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pce_pkg::MAG_W-1:0]   dividend,
    input  logic [pce_pkg::MSUM_W-1:0]  divisor,
    output logic                        done,
    output logic [pce_pkg::MAG_W-1:0]   quotient
);
    localparam int MW    = pce_pkg::MAG_W;
    localparam int DW    = pce_pkg::MSUM_W;
    localparam int CNT_W = $clog2(MW + 1);

    logic [MW-1:0]    quo_reg;
    logic [DW-1:0]    dvs_reg;
    logic [DW-1:0]    rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DW:0]      rem_sh;
    logic             fits;

    // Shift in the next dividend bit and try the subtraction.
    assign rem_sh = {rem_reg, quo_reg[MW-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(MW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) busy_reg <= 1'b0;
        end
    end

    // The dividend register fills with quotient bits as it shifts out.
    // The remainder always stays below the divisor, so it fits DW bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[MW-2:0], fits};
            rem_reg <= fits ? DW'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DW-1:0];
        end
    end

    assign done     = !busy_reg;
    assign quotient = quo_reg;

endmodule

### hw/rtl/particle_collision_engine_core.sv
// Channel | Dir | Handshake   | Items
// req     | in  | valid/ready | load, advance, wall check or pair check
// res     | out | valid/ready | one item per request, two for a pair check
// wr_*    | in  | write enable| configuration registers, no read-back
//
// One request is in work at a time; req.ready is high only when idle.
// A pair check that applies the response waits on the 49-step radix-2 divider, and
// the table port adds reads. Without a response a pair check skips the divider.
// A stalled result item holds the engine until the result register can take it.
// A full result register lets the next request start while the item waits.
// Reset clears control and configuration; table entries are undefined until loaded.
module particle_collision_engine_core #(
    parameter int ENTRIES   = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pce_req_if.sink                         req,
    pce_res_if.source                       res,
    input  logic                            wr_en,
    input  logic [pce_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [pce_pkg::CFG_W-1:0]       wr_data
);
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NW = pce_pkg::NUM_W;
    localparam int MW = pce_pkg::MAG_W;

    // Reduce a request index into the table range.
    function automatic logic [5:0] mod_entries(input logic [5:0] v);
        logic [6:0] r;
        r = '0;
        for (int i = 5; i >= 0; i--)
        begin
            r = {r[5:0], v[i]};
            if (int'(r) >= ENTRIES) r = r - 7'(ENTRIES);
        end
        mod_entries = r[5:0];
    endfunction

    // Does the position lie within the half extent of the bound?
    function automatic logic touch(input logic signed [31:0] pos,
                                   input logic signed [31:0] bound,
                                   input logic [30:0] half);
        logic signed [32:0] d;
        logic [32:0]        ad;
        d  = 33'(bound) - 33'(pos);
        ad = d[32] ? 33'(-d) : 33'(d);
        touch = ad <= {2'b00, half};
    endfunction

    function automatic logic toward(input logic signed [31:0] pos,
                                    input logic signed [31:0] bound,
                                    input logic signed [31:0] vel);
        toward = (pos < bound) == (vel > 32'sd0);
    endfunction

    pce_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic signed [31:0] left_reg, right_reg, bottom_reg, top_reg;
    logic [30:0]        tstep_reg;

    // Request and working registers.
    logic [1:0]             type_reg;
    logic [5:0]             ia_reg, ib_reg;
    pce_pkg::entry_t        ea_reg, eb_reg, mem_q;
    logic                   hit_reg;
    logic signed [63:0]     prod_reg;
    logic signed [33:0]     p1x_reg, p1y_reg, p2x_reg, p2y_reg;
    logic [31:0]            r_reg;
    logic                   sqsq_reg;
    logic [31:0]            ax_reg, ay_reg;
    logic [63:0]            sx_reg, sy_reg, sr_reg;
    logic signed [NW-1:0]   num_reg [4];
    logic [1:0]             cnt_reg;

    // Result register.
    logic               out_valid_reg;
    logic [5:0]         out_entry_reg;
    logic               out_hit_reg;
    logic signed [31:0] out_px_reg, out_py_reg, out_vx_reg, out_vy_reg;
    logic               out_last_reg;

    // Particle table.
    pce_pkg::entry_t mem [ENTRIES];
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    pce_pkg::entry_t mem_wdata;

    logic            accept, out_load;
    logic [5:0]      ia_mod, ib_mod;
    pce_pkg::entry_t load_ent;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == pce_pkg::ST_IDLE);
    assign out_load = ((state_reg == pce_pkg::ST_EMIT_A) || (state_reg == pce_pkg::ST_EMIT_B))
                      && (!out_valid_reg || res.ready);
    assign ia_mod   = mod_entries(req.index_a);
    assign ib_mod   = mod_entries(req.index_b);

    always_comb
    begin
        load_ent.is_square = req.is_square;
        load_ent.pos_x     = req.pos_x;
        load_ent.pos_y     = req.pos_y;
        load_ent.vel_x     = req.vel_x;
        load_ent.vel_y     = req.vel_y;
        load_ent.extent    = req.extent;
        load_ent.mass      = req.mass;
    end

    // Advance: one multiplier shared by the x and y components.
    logic signed [31:0] adv_vel, adv_pos, adv_new;
    logic signed [63:0] adv_prod;
    pce_pkg::entry_t    adv_ent;

    always_comb
    begin
        adv_vel  = (state_reg == pce_pkg::ST_ADV_X) ? ea_reg.vel_x : ea_reg.vel_y;
        adv_prod = 64'(adv_vel) * 64'($signed({1'b0, tstep_reg}));
        adv_pos  = (state_reg == pce_pkg::ST_ADV_Y) ? ea_reg.pos_x : ea_reg.pos_y;
        adv_new  = pce_pkg::sat32(65'(adv_pos) + 65'(prod_reg >>> FRAC_BITS));
        adv_ent  = ea_reg;
        adv_ent.pos_y = adv_new;
    end

    // Wall check: left, right, bottom, top in turn.
    logic [30:0]        wall_half;
    logic signed [31:0] vx1, vx2, vy1, vy2;
    logic               t_l, t_r, t_b, t_t, wall_hit;
    pce_pkg::entry_t    wall_ent;

    always_comb
    begin
        wall_half = ea_reg.is_square ? {1'b0, ea_reg.extent[30:1]} : ea_reg.extent;
        t_l = touch(ea_reg.pos_x, left_reg, wall_half);
        t_r = touch(ea_reg.pos_x, right_reg, wall_half);
        t_b = touch(ea_reg.pos_y, bottom_reg, wall_half);
        t_t = touch(ea_reg.pos_y, top_reg, wall_half);
        vx1 = (t_l && toward(ea_reg.pos_x, left_reg, ea_reg.vel_x))
              ? pce_pkg::neg_sat(ea_reg.vel_x) : ea_reg.vel_x;
        vx2 = (t_r && toward(ea_reg.pos_x, right_reg, vx1)) ? pce_pkg::neg_sat(vx1) : vx1;
        vy1 = (t_b && toward(ea_reg.pos_y, bottom_reg, ea_reg.vel_y))
              ? pce_pkg::neg_sat(ea_reg.vel_y) : ea_reg.vel_y;
        vy2 = (t_t && toward(ea_reg.pos_y, top_reg, vy1)) ? pce_pkg::neg_sat(vy1) : vy1;
        wall_hit = t_l || t_r || t_b || t_t;
        wall_ent = ea_reg;
        wall_ent.vel_x = vx2;
        wall_ent.vel_y = vy2;
    end

    // Overlap setup: the two points to compare and the reach between them.
    pce_pkg::entry_t    c_ent, s_ent;
    logic [31:0]        ext_sum;
    logic [30:0]        half_s;
    logic signed [33:0] lo_x, hi_x, lo_y, hi_y, cx, cy, qx, qy;
    logic signed [33:0] o_p1x, o_p1y, o_p2x, o_p2y;
    logic [31:0]        o_r;

    always_comb
    begin
        ext_sum = {1'b0, ea_reg.extent} + {1'b0, eb_reg.extent};
        c_ent   = ea_reg.is_square ? eb_reg : ea_reg;
        s_ent   = ea_reg.is_square ? ea_reg : eb_reg;
        half_s  = {1'b0, s_ent.extent[30:1]};
        lo_x = 34'(s_ent.pos_x) - $signed({3'b000, half_s});
        hi_x = 34'(s_ent.pos_x) + $signed({3'b000, half_s});
        lo_y = 34'(s_ent.pos_y) - $signed({3'b000, half_s});
        hi_y = 34'(s_ent.pos_y) + $signed({3'b000, half_s});
        cx = 34'(c_ent.pos_x);
        cy = 34'(c_ent.pos_y);
        qx = (cx < lo_x) ? lo_x : ((cx > hi_x) ? hi_x : cx);
        qy = (cy < lo_y) ? lo_y : ((cy > hi_y) ? hi_y : cy);
        if (ea_reg.is_square == eb_reg.is_square)
        begin
            o_p1x = 34'(ea_reg.pos_x);
            o_p1y = 34'(ea_reg.pos_y);
            o_p2x = 34'(eb_reg.pos_x);
            o_p2y = 34'(eb_reg.pos_y);
            o_r   = ea_reg.is_square ? (ext_sum >> 1) : ext_sum;
        end
        else
        begin
            o_p1x = qx;
            o_p1y = qy;
            o_p2x = cx;
            o_p2y = cy;
            o_r   = {1'b0, c_ent.extent};
        end
    end

    // Overlap distance and squares.
    logic signed [34:0] dx, dy;
    logic [33:0]        adx, ady, amax;
    logic               out_of_reach, sq_hit, sum_hit, hit_now, mass_nz;
    logic [31:0]        sq_op;
    logic [63:0]        sq;

    always_comb
    begin
        dx  = 35'(p1x_reg) - 35'(p2x_reg);
        dy  = 35'(p1y_reg) - 35'(p2y_reg);
        adx = dx[34] ? 34'(-dx) : 34'(dx);
        ady = dy[34] ? 34'(-dy) : 34'(dy);
        amax = (adx > ady) ? adx : ady;
        out_of_reach = (adx > {2'b00, r_reg}) || (ady > {2'b00, r_reg});
        sq_hit  = amax <= {2'b00, r_reg};
        case (state_reg)
            pce_pkg::ST_SQ_X: sq_op = ax_reg;
            pce_pkg::ST_SQ_Y: sq_op = ay_reg;
            default:          sq_op = r_reg;
        endcase
        sq      = 64'(sq_op) * 64'(sq_op);
        sum_hit = ({1'b0, sx_reg} + {1'b0, sy_reg}) <= {1'b0, sr_reg};
        if (state_reg == pce_pkg::ST_SQ_CMP) hit_now = sum_hit;
        else hit_now = sqsq_reg && sq_hit;
        mass_nz = (ea_reg.mass | eb_reg.mass) != '0;
    end

    // Response numerator for one lane: v1*(m1-m2) + v2*2*m2.
    pce_pkg::entry_t        e1, e2;
    logic signed [31:0]     v1, v2;
    logic signed [16:0]     dm;
    logic signed [17:0]     tm;
    logic signed [NW-1:0]   num;

    always_comb
    begin
        e1 = cnt_reg[1] ? eb_reg : ea_reg;
        e2 = cnt_reg[1] ? ea_reg : eb_reg;
        v1 = cnt_reg[0] ? e1.vel_y : e1.vel_x;
        v2 = cnt_reg[0] ? e2.vel_y : e2.vel_x;
        dm = $signed({1'b0, e1.mass}) - $signed({1'b0, e2.mass});
        tm = $signed({1'b0, e2.mass, 1'b0});
        num = NW'(v1) * NW'(dm) + NW'(v2) * NW'(tm);
    end

    // Four divider lanes, one for each velocity component.
    logic [MW-1:0]               div_dvd [4];
    logic [MW-1:0]               div_q   [4];
    logic [3:0]                  div_done;
    logic [NW-1:0]               neg_num [4];
    logic [pce_pkg::MSUM_W-1:0]  msum;
    logic signed [31:0]          nv      [4];
    logic                        div_start;

    assign msum      = {1'b0, ea_reg.mass} + {1'b0, eb_reg.mass};
    assign div_start = (state_reg == pce_pkg::ST_DIV_GO);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            neg_num[k] = -num_reg[k];
            div_dvd[k] = num_reg[k][NW-1] ? neg_num[k][MW-1:0] : num_reg[k][MW-1:0];
            nv[k]      = pce_pkg::quot_to_vel(div_q[k], num_reg[k][NW-1]);
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_div
        pce_div u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (div_dvd[g]),
            .divisor  (msum),
            .done     (div_done[g]),
            .quotient (div_q[g])
        );
    end

    // Table port selection.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = AW'(ia_reg);
        mem_wdata = ea_reg;
        mem_re    = 1'b0;
        mem_raddr = AW'(ia_reg);
        case (state_reg)
            pce_pkg::ST_IDLE:
            begin
                mem_we    = accept && (req.req_type == pce_pkg::REQ_LOAD);
                mem_waddr = AW'(ia_mod);
                mem_wdata = load_ent;
            end
            pce_pkg::ST_RD_A:   mem_re = 1'b1;
            pce_pkg::ST_RD_B:
            begin
                mem_re    = 1'b1;
                mem_raddr = AW'(ib_reg);
            end
            pce_pkg::ST_ADV_PY:
            begin
                mem_we    = 1'b1;
                mem_wdata = adv_ent;
            end
            pce_pkg::ST_WALL:
            begin
                mem_we    = 1'b1;
                mem_wdata = wall_ent;
            end
            pce_pkg::ST_WB_A:   mem_we = 1'b1;
            pce_pkg::ST_WB_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(ib_reg);
                mem_wdata = eb_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) mem_q <= mem[mem_raddr];
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= pce_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pce_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == pce_pkg::REQ_LOAD) state_next = pce_pkg::ST_EMIT_A;
                    else state_next = pce_pkg::ST_RD_A;
                end
            end
            pce_pkg::ST_RD_A:  state_next = pce_pkg::ST_RD_B;
            pce_pkg::ST_RD_B:
            begin
                case (type_reg)
                    pce_pkg::REQ_ADVANCE: state_next = pce_pkg::ST_ADV_X;
                    pce_pkg::REQ_WALL:    state_next = pce_pkg::ST_WALL;
                    default:              state_next = pce_pkg::ST_CAP_B;
                endcase
            end
            pce_pkg::ST_CAP_B:  state_next = pce_pkg::ST_OVL0;
            pce_pkg::ST_ADV_X:  state_next = pce_pkg::ST_ADV_Y;
            pce_pkg::ST_ADV_Y:  state_next = pce_pkg::ST_ADV_PY;
            pce_pkg::ST_ADV_PY: state_next = pce_pkg::ST_EMIT_A;
            pce_pkg::ST_WALL:   state_next = pce_pkg::ST_EMIT_A;
            pce_pkg::ST_OVL0:   state_next = pce_pkg::ST_OVL1;
            pce_pkg::ST_OVL1:
            begin
                if (!sqsq_reg && !out_of_reach) state_next = pce_pkg::ST_SQ_X;
                else if (hit_now && mass_nz) state_next = pce_pkg::ST_NUM;
                else state_next = pce_pkg::ST_EMIT_A;
            end
            pce_pkg::ST_SQ_X:   state_next = pce_pkg::ST_SQ_Y;
            pce_pkg::ST_SQ_Y:   state_next = pce_pkg::ST_SQ_R;
            pce_pkg::ST_SQ_R:   state_next = pce_pkg::ST_SQ_CMP;
            pce_pkg::ST_SQ_CMP:
            begin
                if (hit_now && mass_nz) state_next = pce_pkg::ST_NUM;
                else state_next = pce_pkg::ST_EMIT_A;
            end
            pce_pkg::ST_NUM:
            begin
                if (cnt_reg == 2'd3) state_next = pce_pkg::ST_DIV_GO;
            end
            pce_pkg::ST_DIV_GO: state_next = pce_pkg::ST_DIV_WAIT;
            pce_pkg::ST_DIV_WAIT:
            begin
                if (&div_done) state_next = pce_pkg::ST_RESP;
            end
            pce_pkg::ST_RESP:   state_next = pce_pkg::ST_WB_A;
            pce_pkg::ST_WB_A:   state_next = pce_pkg::ST_WB_B;
            pce_pkg::ST_WB_B:   state_next = pce_pkg::ST_EMIT_A;
            pce_pkg::ST_EMIT_A:
            begin
                if (out_load)
                begin
                    if (type_reg == pce_pkg::REQ_PAIR) state_next = pce_pkg::ST_EMIT_B;
                    else state_next = pce_pkg::ST_IDLE;
                end
            end
            pce_pkg::ST_EMIT_B:
            begin
                if (out_load) state_next = pce_pkg::ST_IDLE;
            end
            default:            state_next = pce_pkg::ST_IDLE;
        endcase
    end

    // Lane counter for the numerators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) cnt_reg <= '0;
        else if (state_reg == pce_pkg::ST_NUM) cnt_reg <= cnt_reg + 2'd1;
        else cnt_reg <= '0;
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            pce_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    type_reg <= req.req_type;
                    ia_reg   <= ia_mod;
                    ib_reg   <= ib_mod;
                    hit_reg  <= 1'b0;
                    ea_reg   <= load_ent;
                end
            end
            pce_pkg::ST_RD_B:   ea_reg <= mem_q;
            pce_pkg::ST_CAP_B:  eb_reg <= mem_q;
            pce_pkg::ST_ADV_X:  prod_reg <= adv_prod;
            pce_pkg::ST_ADV_Y:
            begin
                ea_reg.pos_x <= adv_new;
                prod_reg     <= adv_prod;
            end
            pce_pkg::ST_ADV_PY: ea_reg <= adv_ent;
            pce_pkg::ST_WALL:
            begin
                ea_reg  <= wall_ent;
                hit_reg <= wall_hit;
            end
            pce_pkg::ST_OVL0:
            begin
                p1x_reg  <= o_p1x;
                p1y_reg  <= o_p1y;
                p2x_reg  <= o_p2x;
                p2y_reg  <= o_p2y;
                r_reg    <= o_r;
                sqsq_reg <= ea_reg.is_square && eb_reg.is_square;
            end
            pce_pkg::ST_OVL1:
            begin
                ax_reg  <= adx[31:0];
                ay_reg  <= ady[31:0];
                hit_reg <= hit_now;
            end
            pce_pkg::ST_SQ_X:   sx_reg <= sq;
            pce_pkg::ST_SQ_Y:   sy_reg <= sq;
            pce_pkg::ST_SQ_R:   sr_reg <= sq;
            pce_pkg::ST_SQ_CMP: hit_reg <= hit_now;
            pce_pkg::ST_NUM:    num_reg[cnt_reg] <= num;
            pce_pkg::ST_RESP:
            begin
                // The same entry twice ends with the second particle's response.
                ea_reg.vel_x <= (ia_reg == ib_reg) ? nv[2] : nv[0];
                ea_reg.vel_y <= (ia_reg == ib_reg) ? nv[3] : nv[1];
                eb_reg.vel_x <= nv[2];
                eb_reg.vel_y <= nv[3];
            end
            default:
            begin
                hit_reg <= hit_reg;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            top_reg    <= '0;
            tstep_reg  <= 31'(1) << FRAC_BITS;
        end
        else if (wr_en)
        begin
            case (wr_index)
                pce_pkg::CFG_LEFT:   left_reg   <= wr_data;
                pce_pkg::CFG_RIGHT:  right_reg  <= wr_data;
                pce_pkg::CFG_BOTTOM: bottom_reg <= wr_data;
                pce_pkg::CFG_TOP:    top_reg    <= wr_data;
                pce_pkg::CFG_TSTEP:  tstep_reg  <= wr_data[30:0];
                default:             tstep_reg  <= tstep_reg;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (out_load) out_valid_reg <= 1'b1;
        else if (res.ready) out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg <= hit_reg;
            if (state_reg == pce_pkg::ST_EMIT_B)
            begin
                out_entry_reg <= ib_reg;
                out_px_reg    <= eb_reg.pos_x;
                out_py_reg    <= eb_reg.pos_y;
                out_vx_reg    <= eb_reg.vel_x;
                out_vy_reg    <= eb_reg.vel_y;
                out_last_reg  <= 1'b1;
            end
            else
            begin
                out_entry_reg <= ia_reg;
                out_px_reg    <= ea_reg.pos_x;
                out_py_reg    <= ea_reg.pos_y;
                out_vx_reg    <= ea_reg.vel_x;
                out_vy_reg    <= ea_reg.vel_y;
                out_last_reg  <= (type_reg != pce_pkg::REQ_PAIR);
            end
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.entry     = out_entry_reg;
    assign res.hit       = out_hit_reg;
    assign res.new_pos_x = out_px_reg;
    assign res.new_pos_y = out_py_reg;
    assign res.new_vel_x = out_vx_reg;
    assign res.new_vel_y = out_vy_reg;
    assign res.last      = out_last_reg;

endmodule
